/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the checker files of the register bank.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and idle while rst_n is low.
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, sampled on clk and idle while rst_n is low.
`define ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* hw/rtl/ubrf_pkg.sv */
// Package with types, register offsets and constants of the UART register bank.
`timescale 1ns / 1ps

package ubrf_pkg;

    localparam int NUM_UNITS = 3;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Register offsets inside one unit window.
    localparam logic [7:0] OFF_EFR_FCR = 8'h08;
    localparam logic [7:0] OFF_LCR     = 8'h0c;
    localparam logic [7:0] OFF_MCR     = 8'h10;
    localparam logic [7:0] OFF_TLR_SPR = 8'h1c;
    localparam logic [7:0] OFF_SUPP    = 8'h40;
    localparam logic [7:0] OFF_SYSC    = 8'h54;
    localparam logic [7:0] OFF_SYSS    = 8'h58;

    localparam logic [7:0] LCR_CONFIG_B  = 8'hbf;
    localparam logic [7:0] FCR_CLR_BITS  = 8'h06;
    localparam logic [7:0] MCR_MASK_FULL = 8'hff;
    localparam logic [7:0] MCR_MASK_LOW  = 8'h1f;
    localparam logic [7:0] SOFT_RESET    = 8'h02;
    localparam logic [7:0] RESET_DONE    = 8'h01;

    localparam int EFR_ENH_BIT  = 4;
    localparam int MCR_TCR_BIT  = 6;

    typedef struct packed {
        logic       cmd;
        logic [1:0] unit_index;
        logic [7:0] reg_offset;
        logic [7:0] write_data;
    } req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       fault;
    } rsp_t;

    typedef struct packed {
        logic [7:0] line_ctrl;
        logic [7:0] enh_feature;
        logic [7:0] fifo_ctrl;
        logic [7:0] modem_ctrl;
        logic [7:0] supp_ctrl;
        logic [7:0] scratchpad;
        logic [7:0] trig_level;
        logic [7:0] sys_config;
        logic [7:0] sys_status;
    } unit_regs_t;

    localparam unit_regs_t UNIT_RESET_VAL = '{
        line_ctrl:   8'h00,
        enh_feature: 8'h00,
        fifo_ctrl:   8'h00,
        modem_ctrl:  8'h00,
        supp_ctrl:   8'h00,
        scratchpad:  8'h00,
        trig_level:  8'h00,
        sys_config:  8'h00,
        sys_status:  RESET_DONE
    };

    // Flow control between the input stage and the output stage.
    typedef struct packed {
        logic advance;
    } flow_t;

endpackage

/* hw/rtl/ubrf_if.sv */
// Valid/ready channel interfaces for register accesses and their results.
`timescale 1ns / 1ps

interface ubrf_req_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [1:0] unit_index;
    logic [7:0] reg_offset;
    logic [7:0] write_data;

    modport source (output valid, output cmd, output unit_index, output reg_offset,
                    output write_data, input ready);
    modport sink   (input valid, input cmd, input unit_index, input reg_offset,
                    input write_data, output ready);
endinterface

interface ubrf_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       fault;

    modport source (output valid, output read_data, output fault, input ready);
    modport sink   (input valid, input read_data, input fault, output ready);
endinterface

/* hw/rtl/ubrf_in_stage.sv */
// Input register that captures one access per transfer.
`timescale 1ns / 1ps

module ubrf_in_stage
(
    input  logic            clk,
    input  logic            rst_n,
    ubrf_req_if.sink        req,
    input  ubrf_pkg::flow_t flow,
    output logic            s1_valid,
    output ubrf_pkg::req_t  s1_req
);

    logic           valid_reg;
    logic           valid_next;
    ubrf_pkg::req_t req_reg;
    logic           take;

    // The stage is free when empty or when its item moves on this cycle.
    assign req.ready = !valid_reg || flow.advance;
    assign take      = req.valid && req.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (flow.advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            req_reg.cmd        <= req.cmd;
            req_reg.unit_index <= req.unit_index;
            req_reg.reg_offset <= req.reg_offset;
            req_reg.write_data <= req.write_data;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_req   = req_reg;

endmodule

/* hw/rtl/ubrf_regbank.sv */
// Per-unit register storage with the address decode and update logic.
`timescale 1ns / 1ps

module ubrf_regbank
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  ubrf_pkg::req_t  s1_req,
    output ubrf_pkg::rsp_t  result
);

    ubrf_pkg::unit_regs_t bank_reg [ubrf_pkg::NUM_UNITS];
    ubrf_pkg::unit_regs_t cur;
    ubrf_pkg::unit_regs_t upd_next;
    logic                 unit_ok;
    logic                 wr;
    logic                 flt;
    logic [7:0]           rd;
    logic [7:0]           d;
    logic [7:0]           mcr_mask;
    logic [7:0]           sysc_val;
    logic                 cfg_mode;
    logic                 tlr_sel;
    logic                 commit;

    always_comb
    begin
        cur     = ubrf_pkg::UNIT_RESET_VAL;
        unit_ok = 1'b0;
        for (int i = 0; i < ubrf_pkg::NUM_UNITS; i++)
        begin
            if (int'(s1_req.unit_index) == i)
            begin
                cur     = bank_reg[i];
                unit_ok = 1'b1;
            end
        end
    end

    assign wr       = (s1_req.cmd == ubrf_pkg::CMD_WRITE);
    assign d        = s1_req.write_data;
    assign cfg_mode = (cur.line_ctrl == ubrf_pkg::LCR_CONFIG_B);
    assign tlr_sel  = cur.enh_feature[ubrf_pkg::EFR_ENH_BIT]
                      && cur.modem_ctrl[ubrf_pkg::MCR_TCR_BIT];
    assign mcr_mask = cur.enh_feature[ubrf_pkg::EFR_ENH_BIT] ? ubrf_pkg::MCR_MASK_FULL
                                                             : ubrf_pkg::MCR_MASK_LOW;
    assign sysc_val = d & ~ubrf_pkg::SOFT_RESET;

    always_comb
    begin
        upd_next = cur;
        rd       = 8'h00;
        flt      = 1'b0;
        case (s1_req.reg_offset)
            ubrf_pkg::OFF_EFR_FCR:
            begin
                if (cfg_mode)
                begin
                    if (wr)
                    begin
                        upd_next.enh_feature = d;
                    end
                    rd = wr ? d : cur.enh_feature;
                end
                else if (wr)
                begin
                    upd_next.fifo_ctrl = d & ~ubrf_pkg::FCR_CLR_BITS;
                end
                else
                begin
                    flt = 1'b1;
                end
            end
            ubrf_pkg::OFF_LCR:
            begin
                if (wr)
                begin
                    upd_next.line_ctrl = d;
                end
                rd = wr ? d : cur.line_ctrl;
            end
            ubrf_pkg::OFF_MCR:
            begin
                if (cfg_mode)
                begin
                    flt = 1'b1;
                end
                else if (wr)
                begin
                    upd_next.modem_ctrl = (cur.modem_ctrl & ~mcr_mask) | (d & mcr_mask);
                    rd = d;
                end
                else
                begin
                    rd = cur.modem_ctrl;
                end
            end
            ubrf_pkg::OFF_TLR_SPR:
            begin
                if (tlr_sel)
                begin
                    if (wr)
                    begin
                        upd_next.trig_level = d;
                    end
                    rd = wr ? d : cur.trig_level;
                end
                else if (cfg_mode)
                begin
                    flt = 1'b1;
                end
                else
                begin
                    if (wr)
                    begin
                        upd_next.scratchpad = d;
                    end
                    rd = wr ? d : cur.scratchpad;
                end
            end
            ubrf_pkg::OFF_SUPP:
            begin
                if (wr)
                begin
                    upd_next.supp_ctrl = d;
                end
                rd = wr ? d : cur.supp_ctrl;
            end
            ubrf_pkg::OFF_SYSC:
            begin
                if (wr)
                begin
                    // A soft reset clears the whole unit before the byte lands.
                    if ((d & ubrf_pkg::SOFT_RESET) != 8'h00)
                    begin
                        upd_next            = ubrf_pkg::UNIT_RESET_VAL;
                        upd_next.sys_config = sysc_val;
                    end
                    else
                    begin
                        upd_next.sys_config = d;
                    end
                    rd = sysc_val;
                end
                else
                begin
                    rd = cur.sys_config;
                end
            end
            ubrf_pkg::OFF_SYSS:
            begin
                rd = cur.sys_status;
            end
            default:
            begin
                flt = 1'b1;
            end
        endcase
        if (!unit_ok)
        begin
            flt = 1'b1;
        end
    end

    assign result.read_data = flt ? 8'h00 : rd;
    assign result.fault     = flt;
    assign commit           = advance && wr && !flt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ubrf_pkg::NUM_UNITS; i++)
            begin
                bank_reg[i] <= ubrf_pkg::UNIT_RESET_VAL;
            end
        end
        else
        begin
            for (int i = 0; i < ubrf_pkg::NUM_UNITS; i++)
            begin
                if (commit && int'(s1_req.unit_index) == i)
                begin
                    bank_reg[i] <= upd_next;
                end
            end
        end
    end

endmodule

/* hw/rtl/ubrf_out_stage.sv */
// Result register that holds one result until its transfer completes.
`timescale 1ns / 1ps

module ubrf_out_stage
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  ubrf_pkg::rsp_t  result,
    ubrf_rsp_if.source      rsp,
    output logic            stall
);

    logic           valid_reg;
    logic           valid_next;
    ubrf_pkg::rsp_t rsp_reg;

    assign stall = valid_reg && !rsp.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp.valid     = valid_reg;
    assign rsp.read_data = rsp_reg.read_data;
    assign rsp.fault     = rsp_reg.fault;

endmodule

/* hw/rtl/uart_banked_register_file_top.sv */
// Top level of the banked UART register file.
//
// Usage:
//   req carries one register access per transfer: cmd (0 read, 1 write),
//   unit_index, reg_offset and write_data. rsp returns read_data and fault
//   for every access, in order, one result per access.
//   An access is captured in an input register, decoded combinationally
//   against the addressed unit's registers, and its result lands in an
//   output register. One access per cycle is sustained while rsp does
//   not stall. Writes take effect when the access moves to the output
//   register, so a following access always sees them.
//   Reset puts every unit's registers to their reset values (the reset-done
//   bit of the status register set) and empties both registers.
//   When rsp is stalled the result holds; one more access waits in the input
//   register, and req.ready drops only once both are occupied.
`timescale 1ns / 1ps

module uart_banked_register_file_top
(
    input  logic       clk,
    input  logic       rst_n,
    ubrf_req_if.sink   req,
    ubrf_rsp_if.source rsp
);

    ubrf_pkg::flow_t flow;
    logic            s1_valid;
    ubrf_pkg::req_t  s1_req;
    ubrf_pkg::rsp_t  result;
    logic            out_stall;

    assign flow.advance   = s1_valid && !out_stall;

    ubrf_in_stage u_in_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .flow     (flow),
        .s1_valid (s1_valid),
        .s1_req   (s1_req)
    );

    ubrf_regbank u_regbank
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (flow.advance),
        .s1_req  (s1_req),
        .result  (result)
    );

    ubrf_out_stage u_out_stage
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (flow.advance),
        .result (result),
        .rsp    (rsp),
        .stall  (out_stall)
    );

endmodule

/* hw/rtl/ubrf_checker.sv */
// Port-level checker of the register bank, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ubrf_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [7:0] rsp_read_data,
    input logic       rsp_fault
);

    // A faulted access never returns data.
    `ASSERT_IMP(a_fault_zero, rsp_valid && rsp_fault, rsp_read_data == 8'h00)

    // With no result waiting, the block always takes a new access.
    `ASSERT_IMP(a_ready_when_free, !rsp_valid, req_ready)

    // A stalled result stays on the channel unchanged.
    `ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready,
                rsp_valid && $stable(rsp_read_data) && $stable(rsp_fault))

    // A request waiting on a full pipeline implies a result is being held.
    `ASSERT_IMP(a_stall_cause, req_valid && !req_ready, rsp_valid && !rsp_ready)

endmodule

bind uart_banked_register_file_top ubrf_checker u_ubrf_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_read_data (rsp.read_data),
    .rsp_fault     (rsp.fault)
);

/* test/uart_banked_register_file_top_test.sv */
// Testbench of the banked UART register file: directed and random accesses checked in order.
`timescale 1ns / 1ps

module uart_banked_register_file_top_test;

    localparam int RANDOM_ACCESSES = 550;
    localparam int IDLE_PCT        = 24;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int MAX_REPORTS     = 10;

    localparam logic RD = ubrf_pkg::CMD_READ;
    localparam logic WR = ubrf_pkg::CMD_WRITE;

    typedef struct {
        ubrf_pkg::req_t acc;
        bit             typed;
        ubrf_pkg::rsp_t want;
    } access_row_t;

    logic clk;
    logic rst_n;

    ubrf_req_if req_ch();
    ubrf_rsp_if rsp_ch();

    uart_banked_register_file_top dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    ubrf_pkg::unit_regs_t bank_state[ubrf_pkg::NUM_UNITS];
    ubrf_pkg::rsp_t       pending_results[$];
    access_row_t          access_table[$];
    int unsigned          mismatch_count = 0;
    int unsigned          cycle_count = 0;
    bit                   no_idle;

    localparam logic [7:0] KNOWN_OFFSETS[7] = '{ubrf_pkg::OFF_EFR_FCR, ubrf_pkg::OFF_LCR,
                                                 ubrf_pkg::OFF_MCR, ubrf_pkg::OFF_TLR_SPR,
                                                 ubrf_pkg::OFF_SUPP, ubrf_pkg::OFF_SYSC,
                                                 ubrf_pkg::OFF_SYSS};

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Applies one access to the mirrored register bank and returns its result.
    function automatic ubrf_pkg::rsp_t apply_access(input ubrf_pkg::req_t a);
        ubrf_pkg::unit_regs_t u;
        logic [7:0]           rd;
        logic [7:0]           d;
        logic [7:0]           msk;
        logic                 flt;
        logic                 wr;
        ubrf_pkg::rsp_t       r;
        rd  = 8'h00;
        flt = 1'b0;
        d   = a.write_data;
        wr  = (a.cmd == ubrf_pkg::CMD_WRITE);
        if (int'(a.unit_index) >= ubrf_pkg::NUM_UNITS)
        begin
            r.read_data = 8'h00;
            r.fault     = 1'b1;
            return r;
        end
        u = bank_state[a.unit_index];
        case (a.reg_offset)
            ubrf_pkg::OFF_EFR_FCR:
                if (u.line_ctrl == ubrf_pkg::LCR_CONFIG_B)
                begin
                    if (wr)
                        u.enh_feature = d;
                    rd = u.enh_feature;
                end
                else if (wr)
                    u.fifo_ctrl = d & ~ubrf_pkg::FCR_CLR_BITS;
                else
                    flt = 1'b1;
            ubrf_pkg::OFF_LCR:
            begin
                if (wr)
                    u.line_ctrl = d;
                rd = u.line_ctrl;
            end
            ubrf_pkg::OFF_MCR:
                if (u.line_ctrl == ubrf_pkg::LCR_CONFIG_B)
                    flt = 1'b1;
                else if (wr)
                begin
                    // The upper modem-control bits are locked until enhanced mode is on.
                    msk = u.enh_feature[ubrf_pkg::EFR_ENH_BIT] ? ubrf_pkg::MCR_MASK_FULL
                                                               : ubrf_pkg::MCR_MASK_LOW;
                    u.modem_ctrl = (u.modem_ctrl & ~msk) | (d & msk);
                    rd = d;
                end
                else
                    rd = u.modem_ctrl;
            ubrf_pkg::OFF_TLR_SPR:
                if (u.enh_feature[ubrf_pkg::EFR_ENH_BIT] && u.modem_ctrl[ubrf_pkg::MCR_TCR_BIT])
                begin
                    if (wr)
                        u.trig_level = d;
                    rd = u.trig_level;
                end
                else if (u.line_ctrl == ubrf_pkg::LCR_CONFIG_B)
                    flt = 1'b1;
                else
                begin
                    if (wr)
                        u.scratchpad = d;
                    rd = u.scratchpad;
                end
            ubrf_pkg::OFF_SUPP:
            begin
                if (wr)
                    u.supp_ctrl = d;
                rd = u.supp_ctrl;
            end
            ubrf_pkg::OFF_SYSC:
            begin
                if (wr)
                begin
                    if ((d & ubrf_pkg::SOFT_RESET) != 8'h00)
                    begin
                        u = ubrf_pkg::UNIT_RESET_VAL;
                        d = d & ~ubrf_pkg::SOFT_RESET;
                    end
                    u.sys_config = d;
                end
                rd = u.sys_config;
            end
            ubrf_pkg::OFF_SYSS:
                rd = u.sys_status;
            default:
                flt = 1'b1;
        endcase
        if (!flt)
            bank_state[a.unit_index] = u;
        r.read_data = flt ? 8'h00 : rd;
        r.fault     = flt;
        return r;
    endfunction

    function automatic access_row_t step_row(input logic c, input logic [1:0] u,
                                             input logic [7:0] o, input logic [7:0] d,
                                             input bit typed = 1'b0,
                                             input logic [7:0] rd = 8'h00,
                                             input logic f = 1'b0);
        access_row_t row;
        row.acc.cmd        = c;
        row.acc.unit_index = u;
        row.acc.reg_offset = o;
        row.acc.write_data = d;
        row.typed          = typed;
        row.want.read_data = rd;
        row.want.fault     = f;
        return row;
    endfunction

    // Mostly valid units and mapped offsets; the configuration value of LCR and
    // the soft-reset bit are steered so that the shared offsets change meaning often.
    function automatic ubrf_pkg::req_t random_access();
        ubrf_pkg::req_t a;
        a.cmd        = 1'($urandom_range(0, 1));
        a.unit_index = ($urandom_range(0, 99) < 90)
                       ? 2'($urandom_range(0, ubrf_pkg::NUM_UNITS - 1))
                       : 2'($urandom_range(0, 3));
        a.reg_offset = ($urandom_range(0, 99) < 85)
                       ? KNOWN_OFFSETS[3'($urandom_range(0, 6))]
                       : 8'($urandom_range(0, 255));
        a.write_data = 8'($urandom_range(0, 255));
        if (a.reg_offset == ubrf_pkg::OFF_LCR && $urandom_range(0, 99) < 35)
            a.write_data = ubrf_pkg::LCR_CONFIG_B;
        if (a.reg_offset == ubrf_pkg::OFF_SYSC && $urandom_range(0, 99) < 75)
            a.write_data = a.write_data & ~ubrf_pkg::SOFT_RESET;
        return a;
    endfunction

    task automatic send_access(input ubrf_pkg::req_t a, input bit typed,
                               input ubrf_pkg::rsp_t want);
        ubrf_pkg::rsp_t predicted;
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.cmd        <= a.cmd;
        req_ch.unit_index <= a.unit_index;
        req_ch.reg_offset <= a.reg_offset;
        req_ch.write_data <= a.write_data;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = apply_access(a);
        pending_results.push_back(typed ? want : predicted);
    endtask

    always @(posedge clk)
        rsp_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        ubrf_pkg::rsp_t got;
        ubrf_pkg::rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.read_data = rsp_ch.read_data;
            got.fault     = rsp_ch.fault;
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result transfer: read_data %h fault %b",
                             got.read_data, got.fault);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.read_data !== want.read_data || got.fault !== want.fault)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"mismatch: expected read_data %h fault %b, ",
                                  "got read_data %h fault %b"},
                                 want.read_data, want.fault, got.read_data, got.fault);
                end
            end
        end
    end

    initial
    begin
        ubrf_pkg::req_t a;
        ubrf_pkg::rsp_t none;
        none              = '0;
        no_idle           = 1'b0;
        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.cmd        <= ubrf_pkg::CMD_READ;
        req_ch.unit_index <= 2'd0;
        req_ch.reg_offset <= 8'h00;
        req_ch.write_data <= 8'h00;
        foreach (bank_state[i])
            bank_state[i] = ubrf_pkg::UNIT_RESET_VAL;

        // Reset values, faults on bad units and unmapped offsets, then each shared offset.
        access_table.push_back(step_row(RD, 2'd0, ubrf_pkg::OFF_LCR, 8'h00,
                                        1'b1, 8'h00, 1'b0));
        access_table.push_back(step_row(RD, 2'd0, ubrf_pkg::OFF_SYSS, 8'h00,
                                        1'b1, 8'h01, 1'b0));
        access_table.push_back(step_row(RD, 2'd3, ubrf_pkg::OFF_LCR, 8'h00,
                                        1'b1, 8'h00, 1'b1));
        access_table.push_back(step_row(WR, 2'd3, ubrf_pkg::OFF_TLR_SPR, 8'hff,
                                        1'b1, 8'h00, 1'b1));
        access_table.push_back(step_row(RD, 2'd0, 8'hff, 8'h00,
                                        1'b1, 8'h00, 1'b1));
        access_table.push_back(step_row(WR, 2'd2, 8'h00, 8'hff,
                                        1'b1, 8'h00, 1'b1));
        access_table.push_back(step_row(RD, 2'd1, ubrf_pkg::OFF_EFR_FCR, 8'h00,
                                        1'b1, 8'h00, 1'b1));
        access_table.push_back(step_row(WR, 2'd1, ubrf_pkg::OFF_EFR_FCR, 8'hff,
                                        1'b1, 8'h00, 1'b0));
        access_table.push_back(step_row(WR, 2'd0, ubrf_pkg::OFF_LCR, 8'hff,
                                        1'b1, 8'hff, 1'b0));
        access_table.push_back(step_row(WR, 2'd0, ubrf_pkg::OFF_LCR, 8'h00,
                                        1'b1, 8'h00, 1'b0));
        access_table.push_back(step_row(WR, 2'd0, ubrf_pkg::OFF_TLR_SPR, 8'hff,
                                        1'b1, 8'hff, 1'b0));
        access_table.push_back(step_row(RD, 2'd0, ubrf_pkg::OFF_TLR_SPR, 8'h00));
        access_table.push_back(step_row(WR, 2'd0, ubrf_pkg::OFF_MCR, 8'hff,
                                        1'b1, 8'hff, 1'b0));
        access_table.push_back(step_row(RD, 2'd0, ubrf_pkg::OFF_MCR, 8'h00));
        access_table.push_back(step_row(WR, 2'd0, ubrf_pkg::OFF_LCR, ubrf_pkg::LCR_CONFIG_B));
        access_table.push_back(step_row(RD, 2'd0, ubrf_pkg::OFF_MCR, 8'h00,
                                        1'b1, 8'h00, 1'b1));
        access_table.push_back(step_row(RD, 2'd0, ubrf_pkg::OFF_TLR_SPR, 8'h00,
                                        1'b1, 8'h00, 1'b1));
        access_table.push_back(step_row(WR, 2'd0, ubrf_pkg::OFF_EFR_FCR, 8'hff));
        access_table.push_back(step_row(RD, 2'd0, ubrf_pkg::OFF_EFR_FCR, 8'h00));
        access_table.push_back(step_row(WR, 2'd0, ubrf_pkg::OFF_LCR, 8'h03));
        access_table.push_back(step_row(WR, 2'd0, ubrf_pkg::OFF_MCR, 8'hff));
        access_table.push_back(step_row(RD, 2'd0, ubrf_pkg::OFF_MCR, 8'h00));
        access_table.push_back(step_row(WR, 2'd0, ubrf_pkg::OFF_TLR_SPR, 8'ha5));
        access_table.push_back(step_row(RD, 2'd0, ubrf_pkg::OFF_TLR_SPR, 8'h00));
        access_table.push_back(step_row(WR, 2'd2, ubrf_pkg::OFF_SUPP, 8'hff));
        access_table.push_back(step_row(WR, 2'd2, ubrf_pkg::OFF_SYSC, 8'hff));
        access_table.push_back(step_row(WR, 2'd0, ubrf_pkg::OFF_SYSC, ubrf_pkg::SOFT_RESET));
        access_table.push_back(step_row(RD, 2'd0, ubrf_pkg::OFF_LCR, 8'h00));
        access_table.push_back(step_row(WR, 2'd0, ubrf_pkg::OFF_SYSS, 8'h00));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (access_table[i])
            send_access(access_table[i].acc, access_table[i].typed, access_table[i].want);

        for (int n = 0; n < RANDOM_ACCESSES; n++)
        begin
            // A long stretch in the middle runs with both sides at full rate.
            no_idle = (n >= 200 && n < 320);
            a = random_access();
            send_access(a, 1'b0, none);
        end
        no_idle = 1'b0;
        req_ch.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
